>>> design/pps_pkg.sv
package pps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int TIME_BITS = 16;
  localparam int PRIO_BITS = 8;

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int RUN_ID_W = 4;
  localparam int WIDE_W = 32;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] burst;
    logic [PRIO_BITS-1:0] prio;
    logic [TIME_BITS-1:0] remaining;
  } pps_entry_t;

  localparam int ENTRY_W = $bits(pps_entry_t);

  typedef struct packed {
    logic [RUN_ID_W-1:0] running_id;
    logic                idle;
    logic                finished;
    logic [WIDE_W-1:0]   finish_time;
    logic [WIDE_W-1:0]   turnaround;
    logic [WIDE_W-1:0]   waiting;
    logic                all_done;
  } pps_result_t;

  // slot number as reported on the result port, low bits only
  function automatic logic [RUN_ID_W-1:0] to_run_id(input logic [IDX_W-1:0] idx);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(idx);
    return w[RUN_ID_W-1:0];
  endfunction

endpackage

>>> design/pps_ram.sv
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pps_out_reg.sv
module pps_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  pps_pkg::pps_result_t res,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pps_pkg::pps_result_t out_res
);

  logic                 valid_r;
  pps_pkg::pps_result_t res_r;

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load && free) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res_r <= res;
    end
  end

endmodule

>>> design/preemptive_priority_scheduler.sv
// Preemptive priority scheduler over a table of up to 16 processes held in a
// single-port-read entry memory. A tick reads every loaded slot once through
// the memory's one read port: the accepting cycle starts the read, the scan
// compares each loaded slot in turn (it is skipped with an empty table), the
// update step writes the served entry back and the finish step hands the
// result to the output register once it is free; the result then waits there
// until the consumer takes it. Only one item is in progress at a time; the
// next item is taken once the tick has left its result in the output
// register.
module preemptive_priority_scheduler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_operation,
  input  logic [pps_pkg::TIME_BITS-1:0]  in_arrival,
  input  logic [pps_pkg::TIME_BITS-1:0]  in_burst,
  input  logic [pps_pkg::PRIO_BITS-1:0]  in_prio_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pps_pkg::RUN_ID_W-1:0]   out_running_id,
  output logic                           out_idle,
  output logic                           out_finished,
  output logic [pps_pkg::WIDE_W-1:0]     out_finish_time,
  output logic [pps_pkg::WIDE_W-1:0]     out_turnaround,
  output logic [pps_pkg::WIDE_W-1:0]     out_waiting,
  output logic                           out_all_done
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [pps_pkg::WIDE_W-1:0]    clock_r, clock_nxt;
  logic [pps_pkg::CNT_W-1:0]     loaded_r, loaded_nxt;
  logic [pps_pkg::CNT_W-1:0]     dcount_r, dcount_nxt;
  logic [pps_pkg::MAX_PROCS-1:0] done_r, done_nxt;
  logic [pps_pkg::IDX_W-1:0]     cnt_r, cnt_nxt;

  logic                      found_r, found_nxt;
  logic [pps_pkg::IDX_W-1:0] best_id_r, best_id_nxt;
  pps_pkg::pps_entry_t       best_r, best_nxt;
  pps_pkg::pps_result_t      res_r, res_nxt;

  logic                      ram_we;
  logic [pps_pkg::IDX_W-1:0] ram_waddr;
  pps_pkg::pps_entry_t       ram_wdata;
  logic [pps_pkg::IDX_W-1:0] ram_raddr;
  pps_pkg::pps_entry_t       ram_rdata;

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  pps_pkg::pps_result_t out_data;
  pps_pkg::pps_result_t out_res;

  logic                         cand_ok;
  logic                         cand_better;
  logic                         scan_last;
  logic [pps_pkg::CNT_W-1:0]    next_slot;
  logic [pps_pkg::TIME_BITS-1:0] rem_new;
  logic                         fin_now;
  logic [pps_pkg::TIME_BITS-1:0] load_burst;
  logic [pps_pkg::WIDE_W-1:0]   tick_clock;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign next_slot = pps_pkg::CNT_W'(cnt_r) + pps_pkg::CNT_W'(1);
  assign scan_last = (next_slot >= loaded_r);

  assign cand_ok = !done_r[cnt_r] &&
                   (pps_pkg::WIDE_W'(ram_rdata.arrival) <= clock_r);
  // strict compare keeps the lower slot on a full tie
  assign cand_better = !found_r ||
                       (ram_rdata.prio < best_r.prio) ||
                       ((ram_rdata.prio == best_r.prio) &&
                        (ram_rdata.arrival < best_r.arrival));

  assign rem_new    = (best_r.remaining != '0) ?
                      best_r.remaining - pps_pkg::TIME_BITS'(1) : best_r.remaining;
  assign fin_now    = found_r && (rem_new == '0);
  assign load_burst = (in_burst == '0) ? pps_pkg::TIME_BITS'(1) : in_burst;
  assign tick_clock = clock_r + pps_pkg::WIDE_W'(1);

  assign ram_raddr = (state_r == S_SCAN) ? next_slot[pps_pkg::IDX_W-1:0] : '0;

  always_comb begin
    state_nxt   = state_r;
    clock_nxt   = clock_r;
    loaded_nxt  = loaded_r;
    dcount_nxt  = dcount_r;
    done_nxt    = done_r;
    cnt_nxt     = cnt_r;
    found_nxt   = found_r;
    best_id_nxt = best_id_r;
    best_nxt    = best_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = loaded_r[pps_pkg::IDX_W-1:0];
    ram_wdata   = '{arrival: in_arrival, burst: load_burst, prio: in_prio_level,
                    remaining: load_burst};
    out_load    = 1'b0;
    out_data    = res_r;
    out_data.waiting = res_r.finished ?
                       res_r.turnaround - pps_pkg::WIDE_W'(best_r.burst) : '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_operation)
            pps_pkg::OP_LOAD: begin
              if (loaded_r < pps_pkg::CNT_W'(pps_pkg::MAX_PROCS)) begin
                ram_we = 1'b1;
                done_nxt[loaded_r[pps_pkg::IDX_W-1:0]] = 1'b0;
                loaded_nxt = loaded_r + pps_pkg::CNT_W'(1);
              end
            end
            pps_pkg::OP_TICK: begin
              cnt_nxt   = '0;
              found_nxt = 1'b0;
              state_nxt = (loaded_r == '0) ? S_UPD : S_SCAN;
            end
            pps_pkg::OP_CLEAR: begin
              clock_nxt  = '0;
              loaded_nxt = '0;
              dcount_nxt = '0;
              done_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (cand_ok && cand_better) begin
          found_nxt   = 1'b1;
          best_id_nxt = cnt_r;
          best_nxt    = ram_rdata;
        end
        cnt_nxt = next_slot[pps_pkg::IDX_W-1:0];
        if (scan_last) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        clock_nxt = tick_clock;
        if (found_r) begin
          ram_we    = 1'b1;
          ram_waddr = best_id_r;
          ram_wdata = '{arrival: best_r.arrival, burst: best_r.burst,
                        prio: best_r.prio, remaining: rem_new};
        end
        if (fin_now) begin
          done_nxt[best_id_r] = 1'b1;
          dcount_nxt = dcount_r + pps_pkg::CNT_W'(1);
        end
        res_nxt.running_id      = found_r ? pps_pkg::to_run_id(best_id_r) : '0;
        res_nxt.idle            = !found_r;
        res_nxt.finished        = fin_now;
        res_nxt.finish_time     = fin_now ? tick_clock : '0;
        res_nxt.turnaround      = fin_now ?
                                  tick_clock - pps_pkg::WIDE_W'(best_r.arrival) : '0;
        res_nxt.waiting         = '0;
        res_nxt.all_done        = (dcount_nxt == loaded_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      clock_r  <= '0;
      loaded_r <= '0;
      dcount_r <= '0;
      done_r   <= '0;
      cnt_r    <= '0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clock_r  <= clock_nxt;
      loaded_r <= loaded_nxt;
      dcount_r <= dcount_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_id_r <= best_id_nxt;
    best_r    <= best_nxt;
    res_r     <= res_nxt;
  end

  // while a slot is written, the sequencer reads only slot 0 and never uses
  // that read data, so the read-old behavior of the memory needs no bypass
  pps_ram #(
    .WIDTH (pps_pkg::ENTRY_W),
    .DEPTH (pps_pkg::MAX_PROCS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pps_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .res       (out_data),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_running_id      = out_res.running_id;
  assign out_idle            = out_res.idle;
  assign out_finished        = out_res.finished;
  assign out_finish_time     = out_res.finish_time;
  assign out_turnaround      = out_res.turnaround;
  assign out_waiting         = out_res.waiting;
  assign out_all_done        = out_res.all_done;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (pps_pkg::CNT_W'(cnt_r) < loaded_r))
    else $error("scan slot beyond loaded entries");

  a_done_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    dcount_r <= loaded_r)
    else $error("done count exceeds loaded count");

  a_fin_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && fin_now) |=> done_r[best_id_r])
    else $error("finished entry not marked done");

  a_idle_not_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_idle) |-> (!out_finished && out_running_id == '0))
    else $error("idle result carries a served entry");

endmodule
